@@ hdl/swpm_pkg.sv @@
// ----------------------------------------------------------------------------
// swpm_pkg
// Shared constants, register indexes and controller/datapath interface types
// of the sliding-window product max/mean unit.
// ----------------------------------------------------------------------------
package swpm_pkg;

	localparam int MAX_TAPS_DEF    = 12;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int TAP_SLOTS     = 12;
	localparam int TAPS_PER_REG  = 4;
	localparam int TAP_W         = 16;
	localparam int TAP_IDX_W     = $clog2(TAP_SLOTS);
	localparam int TAP_COUNT_W   = 4;
	localparam int SAMPLE_W      = 16;
	localparam int PROD_W        = 32;
	localparam int RESULT_W      = 32;
	localparam int SUM_W         = 36;
	localparam int DIGIT_W       = 4;
	localparam int DIV_STEPS     = SUM_W / DIGIT_W;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 64;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_MODE      = 3'd1,
		REG_TAPS_LOW  = 3'd2,
		REG_TAPS_MID  = 3'd3,
		REG_TAPS_HIGH = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                 shift;
		logic                 mul;
		logic                 acc;
		logic                 first;
		logic [TAP_IDX_W-1:0] k;
		logic                 div_load;
		logic                 div_step;
		logic                 load_out;
	} swpm_cmd_t;

	typedef struct packed {
		logic win_full;
		logic last_tap;
		logic mean;
		logic out_free;
	} swpm_status_t;

endpackage

@@ hdl/sliding_window_product_max_mean_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_product_max_mean_unit
// A word that fills no window leaves the input ready; a word that closes a
// window is stepped tap by tap through the single shared tap multiplier
// (one tap a cycle), in mean mode divided by the 9-digit radix-16 divider,
// and its result is loaded into the output register once that is free.
// Flow: one word at a time; the input is busy until the result is loaded.
// Reset: asynchronous, clears taps, mode, fill count and output valid; tap
// count resets to one.
// ----------------------------------------------------------------------------
module sliding_window_product_max_mean_unit
	import swpm_pkg::*;
#(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
	input  logic                  s_tuser,   // [0] new_line
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [RESULT_W-1:0]   m_tdata,   // [31:0] window_value
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	swpm_cmd_t    cmd;
	swpm_status_t st;

	swpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	swpm_dp #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.sample    (s_tdata),
		.new_line  (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// never overwrite a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> st.out_free)
		else $error("result loaded over a pending word");

	// the divider only runs in mean mode
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> st.mean)
		else $error("divider stepped in max mode");

	// input side goes busy only after taking a word
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input went busy without an accepted word");

endmodule

@@ hdl/swpm_div.sv @@
// ----------------------------------------------------------------------------
// swpm_div
// Radix-16 divider of the signed window sum by the tap count, one quotient
// digit per step, truncating toward zero.
// ----------------------------------------------------------------------------
module swpm_div
	import swpm_pkg::*;
(
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic signed [SUM_W-1:0]       dividend,
	input  logic        [TAP_COUNT_W-1:0] divisor,
	output logic signed [RESULT_W-1:0]    quotient
);

	localparam int T_W = TAP_COUNT_W + DIGIT_W;

	logic [TAP_COUNT_W-1:0] rem_q;
	logic [SUM_W-1:0]       dvd_q;
	logic                   neg_q;
	logic [SUM_W-1:0]       mag;
	logic [T_W-1:0]         t;
	logic [T_W-1:0]         div_ext;
	logic [T_W-1:0]         rem_next;
	logic [DIGIT_W-1:0]     digit;
	logic [SUM_W-1:0]       quo_signed;

	assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign div_ext = T_W'(divisor);

	// partial remainder stays below the divisor, so the digit is at most 15
	always_comb begin
		t     = {rem_q, dvd_q[SUM_W-1 -: DIGIT_W]};
		digit = '0;
		for (int j = 1; j < (1 << DIGIT_W); j++) begin
			if (t >= T_W'(T_W'(j) * div_ext))
				digit = digit + DIGIT_W'(1);
		end
		rem_next = T_W'(t - T_W'(T_W'(digit) * div_ext));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvd_q <= mag;
			neg_q <= dividend[SUM_W-1];
		end else if (step) begin
			rem_q <= rem_next[TAP_COUNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-DIGIT_W-1:0], digit};
		end
	end

	assign quo_signed = neg_q ? SUM_W'(-dvd_q) : dvd_q;
	assign quotient   = quo_signed[RESULT_W-1:0];

endmodule

@@ hdl/swpm_dp.sv @@
// ----------------------------------------------------------------------------
// swpm_dp
// Datapath: configuration registers, sample window, tap multiplier,
// max/sum accumulator, divider and output register.
// ----------------------------------------------------------------------------
module swpm_dp
	import swpm_pkg::*;
#(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swpm_cmd_t               cmd,
	output swpm_status_t            st,
	input  logic [SAMPLE_W-1:0]     sample,
	input  logic                    new_line,
	input  logic                    cfg_we,
	input  logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [RESULT_W-1:0]     out_data
);

	localparam int CW  = $clog2(MAX_TAPS + 1);
	localparam int WIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [TAP_COUNT_W-1:0]        tap_count_q;
	logic                          mode_q;
	logic signed [TAP_W-1:0]       taps_q [TAP_SLOTS];
	logic [CW-1:0]                 fill_q;
	logic [CW-1:0]                 fill_next;
	logic signed [SAMPLE_BITS-1:0] win_q [MAX_TAPS];
	logic [TAP_COUNT_W-1:0]        n_eff;
	logic [TAP_COUNT_W-1:0]        widx_full;
	logic signed [TAP_W-1:0]       tap_sel;
	logic signed [SAMPLE_BITS-1:0] smp_sel;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      p_s1;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [PROD_W-1:0]      max_q;
	logic signed [RESULT_W-1:0]    quot;
	logic                          out_valid_q;
	logic [RESULT_W-1:0]           out_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_W'(1);
			mode_q      <= 1'b0;
			for (int i = 0; i < TAP_SLOTS; i++)
				taps_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TAP_COUNT: tap_count_q <= cfg_wdata[TAP_COUNT_W-1:0];
				REG_MODE:      mode_q      <= cfg_wdata[0];
				REG_TAPS_LOW: begin
					for (int i = 0; i < TAPS_PER_REG; i++)
						taps_q[i] <= cfg_wdata[TAP_W*i +: TAP_W];
				end
				REG_TAPS_MID: begin
					for (int i = 0; i < TAPS_PER_REG; i++)
						taps_q[TAPS_PER_REG+i] <= cfg_wdata[TAP_W*i +: TAP_W];
				end
				REG_TAPS_HIGH: begin
					for (int i = 0; i < TAPS_PER_REG; i++)
						taps_q[2*TAPS_PER_REG+i] <= cfg_wdata[TAP_W*i +: TAP_W];
				end
				default: ;
			endcase
		end
	end

	// zero taps count as one, saturate at the window depth
	always_comb begin
		if (tap_count_q == '0)
			n_eff = TAP_COUNT_W'(1);
		else if (tap_count_q > TAP_COUNT_W'(MAX_TAPS))
			n_eff = TAP_COUNT_W'(MAX_TAPS);
		else
			n_eff = tap_count_q;
	end

	// line fill, saturating at the window depth
	always_comb begin
		if (new_line)
			fill_next = CW'(1);
		else if (fill_q == CW'(MAX_TAPS))
			fill_next = fill_q;
		else
			fill_next = CW'(fill_q + CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (cmd.shift)
			fill_q <= fill_next;
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			win_q[0] <= sample[SAMPLE_BITS-1:0];
			for (int i = 1; i < MAX_TAPS; i++)
				win_q[i] <= win_q[i-1];
		end
	end

	// tap k pairs with the sample n-1-k places back
	assign widx_full = TAP_COUNT_W'(n_eff - TAP_COUNT_W'(1) - cmd.k);
	assign tap_sel   = taps_q[cmd.k];
	assign smp_sel   = win_q[widx_full[WIW-1:0]];
	assign prod      = PROD_W'(PROD_W'(tap_sel) * PROD_W'(smp_sel));

	always_ff @(posedge clk) begin
		if (cmd.mul)
			p_s1 <= prod;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			if (cmd.first) begin
				sum_q <= SUM_W'(p_s1);
				max_q <= p_s1;
			end else begin
				sum_q <= SUM_W'(sum_q + SUM_W'(p_s1));
				if (p_s1 > max_q)
					max_q <= p_s1;
			end
		end
	end

	swpm_div u_div (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (sum_q),
		.divisor  (n_eff),
		.quotient (quot)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_data_q <= mode_q ? RESULT_W'(quot) : RESULT_W'(max_q);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign st.win_full = (TAP_COUNT_W'(fill_next) >= n_eff);
	assign st.last_tap = (cmd.k == TAP_IDX_W'(n_eff - TAP_COUNT_W'(1)));
	assign st.mean     = mode_q;
	assign st.out_free = !out_valid_q || out_ready;

endmodule

@@ hdl/swpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// swpm_ctrl
// Sequencer: accepts a word, steps the tap multiplier over the window,
// runs the divider in mean mode and hands the result to the output register.
// ----------------------------------------------------------------------------
module swpm_ctrl
	import swpm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  swpm_status_t st,
	output swpm_cmd_t    cmd
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_LAST,
		S_DLOAD,
		S_DIV,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [TAP_IDX_W-1:0] k_q;
	logic [STEP_W-1:0]    step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (in_valid && st.win_full)
						state_q <= S_MUL;
				end
				S_MUL: begin
					if (st.last_tap)
						state_q <= S_LAST;
					else
						k_q <= TAP_IDX_W'(k_q + TAP_IDX_W'(1));
				end
				S_LAST: state_q <= st.mean ? S_DLOAD : S_OUT;
				S_DLOAD: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= S_OUT;
					else
						step_q <= STEP_W'(step_q + STEP_W'(1));
				end
				S_OUT: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.k        = k_q;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.shift = in_valid;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				cmd.acc   = (k_q != '0);
				cmd.first = (k_q == TAP_IDX_W'(1));
			end
			S_LAST: begin
				// drain the final product
				cmd.acc   = 1'b1;
				cmd.first = (k_q == '0);
			end
			S_DLOAD: cmd.div_load = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_OUT:   cmd.load_out = st.out_free;
			default: ;
		endcase
	end

endmodule
